// ----- src/tac_pkg.sv -----
// Shared types, constants and the solve/verify micro-program for the touch calibration block.
package tac_pkg;

    localparam int RAW_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W         = 64;
    localparam int A_W           = 32;
    localparam int COEF_W        = 32;
    localparam int NUM_COEF      = 6;
    localparam int UPC_W         = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 9;
    localparam int SCR_X_W       = 9;
    localparam int SCR_Y_W       = 8;
    localparam int VERIFY_RADIUS = 25;

    localparam logic [UPC_W-1:0] PC_SOLVE  = 6'd0;
    localparam logic [UPC_W-1:0] PC_VERIFY = 6'd47;

    typedef enum logic [2:0] {
        STAT_STORED     = 3'd0,
        STAT_DEGENERATE = 3'd1,
        STAT_VERIFIED   = 3'd2,
        STAT_FAILED     = 3'd3,
        STAT_CLEARED    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_T0X = 3'd0,
        CFG_T0Y = 3'd1,
        CFG_T1X = 3'd2,
        CFG_T1Y = 3'd3,
        CFG_T2X = 3'd4,
        CFG_T2Y = 3'd5,
        CFG_VX  = 3'd6,
        CFG_VY  = 3'd7
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        UOP_MAC,
        UOP_DIV,
        UOP_CHKDET,
        UOP_ENDSOLVE,
        UOP_ENDVERIFY
    } t_kind;

    typedef enum logic [5:0] {
        SRC_ONE, SRC_FONE,
        SRC_RX0, SRC_RY0, SRC_RX1, SRC_RY1, SRC_RX2, SRC_RY2,
        SRC_PX, SRC_PY,
        SRC_T0X, SRC_T0Y, SRC_T1X, SRC_T1Y, SRC_T2X, SRC_T2Y, SRC_VX, SRC_VY,
        SRC_DX12, SRC_DY12, SRC_C, SRC_DET, SRC_DS, SRC_E, SRC_F, SRC_NUM,
        SRC_DX, SRC_DY,
        SRC_K0, SRC_K1, SRC_K2, SRC_K3, SRC_K4, SRC_K5
    } t_src;

    typedef enum logic [3:0] {
        DST_DX12, DST_DY12, DST_C, DST_DET, DST_DS, DST_E, DST_F, DST_NUM,
        DST_DX, DST_DY
    } t_dst;

    typedef struct packed {
        t_kind      kind;
        t_src       a;
        t_src       b;
        logic       neg;
        logic       first;
        logic       last;
        t_dst       dst;
        logic [2:0] coef;
    } t_uop;

    typedef struct packed {
        logic       store_pt;
        logic [1:0] pt_idx;
        logic       load_probe;
        logic       mul;
        logic       acc;
        logic       div_start;
        logic       coef_we;
        logic       load_out;
        logic       give;
        t_uop       uop;
    } t_dp_cmd;

    typedef struct packed {
        logic det_zero;
        logic verify_pass;
        logic div_done;
    } t_dp_stat;

    function automatic t_uop mk(t_kind k, t_src a, t_src b, logic neg, logic first,
                                logic last, t_dst d, logic [2:0] ci);
        t_uop u;
        u.kind  = k;
        u.a     = a;
        u.b     = b;
        u.neg   = neg;
        u.first = first;
        u.last  = last;
        u.dst   = d;
        u.coef  = ci;
        return u;
    endfunction

    // One axis of the solve: the target difference and cross terms, the three numerators, three divides.
    function automatic t_uop axis_op(logic [4:0] k, logic axis);
        t_src       t0;
        t_src       t1;
        t_src       t2;
        logic [2:0] cb;
        t_uop       u;
        t0 = axis ? SRC_T0Y : SRC_T0X;
        t1 = axis ? SRC_T1Y : SRC_T1X;
        t2 = axis ? SRC_T2Y : SRC_T2X;
        cb = axis ? 3'd3 : 3'd0;
        case (k)
            5'd0:    u = mk(UOP_MAC, SRC_ONE, t1,       1'b0, 1'b1, 1'b0, DST_DS,  3'd0);
            5'd1:    u = mk(UOP_MAC, SRC_ONE, t2,       1'b1, 1'b0, 1'b1, DST_DS,  3'd0);
            5'd2:    u = mk(UOP_MAC, SRC_RY1, t2,       1'b0, 1'b1, 1'b0, DST_E,   3'd0);
            5'd3:    u = mk(UOP_MAC, SRC_RY2, t1,       1'b1, 1'b0, 1'b1, DST_E,   3'd0);
            5'd4:    u = mk(UOP_MAC, SRC_RX1, t2,       1'b0, 1'b1, 1'b0, DST_F,   3'd0);
            5'd5:    u = mk(UOP_MAC, SRC_RX2, t1,       1'b1, 1'b0, 1'b1, DST_F,   3'd0);
            5'd6:    u = mk(UOP_MAC, t0,      SRC_DY12, 1'b0, 1'b1, 1'b0, DST_NUM, 3'd0);
            5'd7:    u = mk(UOP_MAC, SRC_RY0, SRC_DS,   1'b1, 1'b0, 1'b0, DST_NUM, 3'd0);
            5'd8:    u = mk(UOP_MAC, SRC_ONE, SRC_E,    1'b1, 1'b0, 1'b1, DST_NUM, 3'd0);
            5'd9:    u = mk(UOP_DIV, SRC_ONE, SRC_ONE,  1'b0, 1'b0, 1'b0, DST_NUM, cb);
            5'd10:   u = mk(UOP_MAC, SRC_RX0, SRC_DS,   1'b0, 1'b1, 1'b0, DST_NUM, 3'd0);
            5'd11:   u = mk(UOP_MAC, t0,      SRC_DX12, 1'b1, 1'b0, 1'b0, DST_NUM, 3'd0);
            5'd12:   u = mk(UOP_MAC, SRC_ONE, SRC_F,    1'b0, 1'b0, 1'b1, DST_NUM, 3'd0);
            5'd13:   u = mk(UOP_DIV, SRC_ONE, SRC_ONE,  1'b0, 1'b0, 1'b0, DST_NUM, cb + 3'd1);
            5'd14:   u = mk(UOP_MAC, SRC_RX0, SRC_E,    1'b0, 1'b1, 1'b0, DST_NUM, 3'd0);
            5'd15:   u = mk(UOP_MAC, SRC_RY0, SRC_F,    1'b1, 1'b0, 1'b0, DST_NUM, 3'd0);
            5'd16:   u = mk(UOP_MAC, t0,      SRC_C,    1'b0, 1'b0, 1'b1, DST_NUM, 3'd0);
            5'd17:   u = mk(UOP_DIV, SRC_ONE, SRC_ONE,  1'b0, 1'b0, 1'b0, DST_NUM, cb + 3'd2);
            default: u = mk(UOP_ENDSOLVE, SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b0, DST_NUM, 3'd0);
        endcase
        return u;
    endfunction

    function automatic t_uop uop_at(logic [UPC_W-1:0] pc);
        t_uop u;
        if (pc <= 6'd9) begin
            case (pc)
                6'd0: u = mk(UOP_MAC, SRC_ONE, SRC_RX1,  1'b0, 1'b1, 1'b0, DST_DX12, 3'd0);
                6'd1: u = mk(UOP_MAC, SRC_ONE, SRC_RX2,  1'b1, 1'b0, 1'b1, DST_DX12, 3'd0);
                6'd2: u = mk(UOP_MAC, SRC_ONE, SRC_RY1,  1'b0, 1'b1, 1'b0, DST_DY12, 3'd0);
                6'd3: u = mk(UOP_MAC, SRC_ONE, SRC_RY2,  1'b1, 1'b0, 1'b1, DST_DY12, 3'd0);
                6'd4: u = mk(UOP_MAC, SRC_RX1, SRC_RY2,  1'b0, 1'b1, 1'b0, DST_C,    3'd0);
                6'd5: u = mk(UOP_MAC, SRC_RX2, SRC_RY1,  1'b1, 1'b0, 1'b1, DST_C,    3'd0);
                6'd6: u = mk(UOP_MAC, SRC_RX0, SRC_DY12, 1'b0, 1'b1, 1'b0, DST_DET,  3'd0);
                6'd7: u = mk(UOP_MAC, SRC_RY0, SRC_DX12, 1'b1, 1'b0, 1'b0, DST_DET,  3'd0);
                6'd8: u = mk(UOP_MAC, SRC_ONE, SRC_C,    1'b0, 1'b0, 1'b1, DST_DET,  3'd0);
                default: u = mk(UOP_CHKDET, SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b0, DST_DET, 3'd0);
            endcase
        end else if (pc <= 6'd27) begin
            u = axis_op(5'(pc - 6'd10), 1'b0);
        end else if (pc <= 6'd45) begin
            u = axis_op(5'(pc - 6'd28), 1'b1);
        end else if (pc == 6'd46) begin
            u = mk(UOP_ENDSOLVE, SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b0, DST_NUM, 3'd0);
        end else begin
            case (pc)
                6'd47: u = mk(UOP_MAC, SRC_PX,  SRC_K0,   1'b0, 1'b1, 1'b0, DST_DX,  3'd0);
                6'd48: u = mk(UOP_MAC, SRC_PY,  SRC_K1,   1'b0, 1'b0, 1'b0, DST_DX,  3'd0);
                6'd49: u = mk(UOP_MAC, SRC_ONE, SRC_K2,   1'b0, 1'b0, 1'b0, DST_DX,  3'd0);
                6'd50: u = mk(UOP_MAC, SRC_VX,  SRC_FONE, 1'b1, 1'b0, 1'b1, DST_DX,  3'd0);
                6'd51: u = mk(UOP_MAC, SRC_PX,  SRC_K3,   1'b0, 1'b1, 1'b0, DST_DY,  3'd0);
                6'd52: u = mk(UOP_MAC, SRC_PY,  SRC_K4,   1'b0, 1'b0, 1'b0, DST_DY,  3'd0);
                6'd53: u = mk(UOP_MAC, SRC_ONE, SRC_K5,   1'b0, 1'b0, 1'b0, DST_DY,  3'd0);
                6'd54: u = mk(UOP_MAC, SRC_VY,  SRC_FONE, 1'b1, 1'b0, 1'b1, DST_DY,  3'd0);
                6'd55: u = mk(UOP_MAC, SRC_DX,  SRC_DX,   1'b0, 1'b1, 1'b0, DST_NUM, 3'd0);
                6'd56: u = mk(UOP_MAC, SRC_DY,  SRC_DY,   1'b0, 1'b0, 1'b1, DST_NUM, 3'd0);
                default: u = mk(UOP_ENDVERIFY, SRC_ONE, SRC_ONE, 1'b0, 1'b0, 1'b0, DST_NUM, 3'd0);
            endcase
        end
        return u;
    endfunction

endpackage

// ----- src/touch_affine_calibration_top.sv -----
// Top level of the three-point touch calibration block with fourth-point verification.
// A stored point or restart moves the sequencer to its done state; the result register then
//   loads, with output valid, once the output is not stalled.
// The third point runs the solve on one shared multiplier and the bit-serial divider.
// The fourth point runs the verify check; one item is in work at a time.
// Reset (synchronous, active low) clears the point count, sequencer and output valid,
//   and loads the default targets; point and coefficient stores are not cleared.
module touch_affine_calibration_top #(
    parameter int RAW_BITS      = tac_pkg::RAW_BITS_DEF,
    parameter int FRACTION_BITS = tac_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [tac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input item channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [RAW_BITS-1:0]                i_raw_x,
    input  logic [RAW_BITS-1:0]                i_raw_y,
    input  logic                               i_restart,
    // result item channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_status,
    output logic [1:0]                         o_points_taken,
    output logic signed [tac_pkg::COEF_W-1:0]  o_coef_xx,
    output logic signed [tac_pkg::COEF_W-1:0]  o_coef_xy,
    output logic signed [tac_pkg::COEF_W-1:0]  o_coef_x0,
    output logic signed [tac_pkg::COEF_W-1:0]  o_coef_yx,
    output logic signed [tac_pkg::COEF_W-1:0]  o_coef_yy,
    output logic signed [tac_pkg::COEF_W-1:0]  o_coef_y0
);

    // commands from the sequencer and flags back from the datapath
    tac_pkg::t_dp_cmd                   w_cmd;
    tac_pkg::t_dp_stat                  w_stat;
    logic signed [tac_pkg::COEF_W-1:0]  w_coef [tac_pkg::NUM_COEF];

    // hold the item until the sequence ends, then drive the result register
    tac_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_points_taken (o_points_taken),
        .o_cmd          (w_cmd),
        .i_stat         (w_stat)
    );

    // multiply-accumulate, divide and verify arithmetic
    tac_datapath #(
        .RAW_BITS      (RAW_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_raw_x     (i_raw_x),
        .i_raw_y     (i_raw_y),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_coef      (w_coef)
    );

    // coefficient order: x row then y row
    assign o_coef_xx = w_coef[0];
    assign o_coef_xy = w_coef[1];
    assign o_coef_x0 = w_coef[2];
    assign o_coef_yx = w_coef[3];
    assign o_coef_yy = w_coef[4];
    assign o_coef_y0 = w_coef[5];

endmodule

// ----- src/tac_divider.sv -----
// Bit-serial signed divider: trunc(num * 2^F / den), saturated to 32 bits.
module tac_divider #(
    parameter int FRACTION_BITS = tac_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [tac_pkg::ACC_W-1:0]   i_num,
    input  logic signed [tac_pkg::ACC_W-1:0]   i_den,
    output logic                               o_done,
    output logic signed [tac_pkg::COEF_W-1:0]  o_quot
);

    localparam int ACC_W = tac_pkg::ACC_W;
    localparam int DVD_W = ACC_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam int Q_W   = tac_pkg::COEF_W + 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [ACC_W:0]   r_rem;
    logic [ACC_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;
    logic             r_ovf;
    logic             r_neg;

    logic [ACC_W-1:0] w_num_mag;
    logic [ACC_W-1:0] w_den_mag;
    logic [ACC_W:0]   w_rem_sh;
    logic [ACC_W+1:0] w_diff;
    logic             w_qbit;

    assign w_num_mag = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign w_den_mag = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
    assign w_rem_sh  = {r_rem[ACC_W-1:0], r_dvd[DVD_W-1]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_qbit    = ~w_diff[ACC_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // restoring shift-subtract, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {w_num_mag, {FRACTION_BITS{1'b0}}};
            r_den <= w_den_mag;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_qbit ? w_diff[ACC_W:0] : w_rem_sh;
            r_q   <= {r_q[Q_W-2:0], w_qbit};
            r_ovf <= r_ovf | r_q[Q_W-1];
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_ovf || r_q[Q_W-1] || (r_q[Q_W-2] && (|r_q[Q_W-3:0]))) begin
                o_quot = {1'b1, {(tac_pkg::COEF_W-1){1'b0}}};
            end else begin
                o_quot = -$signed(r_q[tac_pkg::COEF_W-1:0]);
            end
        end else begin
            if (r_ovf || r_q[Q_W-1] || r_q[Q_W-2]) begin
                o_quot = {1'b0, {(tac_pkg::COEF_W-1){1'b1}}};
            end else begin
                o_quot = $signed(r_q[tac_pkg::COEF_W-1:0]);
            end
        end
    end

    assign o_done = r_done;

endmodule

// ----- src/tac_datapath.sv -----
// Datapath: targets, stored points, shared multiply-accumulate, divider and result coefficients.
module tac_datapath #(
    parameter int RAW_BITS      = tac_pkg::RAW_BITS_DEF,
    parameter int FRACTION_BITS = tac_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tac_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tac_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic [RAW_BITS-1:0]                   i_raw_x,
    input  logic [RAW_BITS-1:0]                   i_raw_y,
    input  tac_pkg::t_dp_cmd                      i_cmd,
    output tac_pkg::t_dp_stat                     o_stat,
    output logic signed [tac_pkg::COEF_W-1:0]     o_coef [tac_pkg::NUM_COEF]
);

    localparam int ACC_W  = tac_pkg::ACC_W;
    localparam int A_W    = tac_pkg::A_W;
    localparam int B_W    = (2 * RAW_BITS + 2 > 34) ? 2 * RAW_BITS + 2 : 34;
    localparam int NC     = tac_pkg::NUM_COEF;
    localparam logic signed [ACC_W-1:0] LIM =
        ACC_W'(tac_pkg::VERIFY_RADIUS) <<< FRACTION_BITS;
    localparam logic signed [ACC_W-1:0] LIM_SQ = LIM * LIM;

    logic [tac_pkg::SCR_X_W-1:0] r_t0x, r_t1x, r_t2x, r_vx;
    logic [tac_pkg::SCR_Y_W-1:0] r_t0y, r_t1y, r_t2y, r_vy;

    logic [RAW_BITS-1:0] r_rx [3];
    logic [RAW_BITS-1:0] r_ry [3];
    logic [RAW_BITS-1:0] r_px;
    logic [RAW_BITS-1:0] r_py;

    logic signed [ACC_W-1:0] r_dx12, r_dy12, r_c, r_det, r_ds, r_e, r_f, r_num, r_dx, r_dy;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    logic signed [tac_pkg::COEF_W-1:0] r_coef [NC];
    logic signed [tac_pkg::COEF_W-1:0] r_out_coef [NC];

    logic signed [ACC_W-1:0]     w_a_full;
    logic signed [ACC_W-1:0]     w_b_full;
    logic signed [A_W-1:0]       w_a;
    logic signed [B_W-1:0]       w_b;
    logic signed [A_W+B_W-1:0]   w_prod;
    logic                        w_div_done;
    logic signed [tac_pkg::COEF_W-1:0] w_quot;

    function automatic logic signed [ACC_W-1:0] src_val(tac_pkg::t_src s);
        logic signed [ACC_W-1:0] v;
        case (s)
            tac_pkg::SRC_ONE:  v = ACC_W'(1);
            tac_pkg::SRC_FONE: v = ACC_W'(1) <<< FRACTION_BITS;
            tac_pkg::SRC_RX0:  v = ACC_W'(r_rx[0]);
            tac_pkg::SRC_RY0:  v = ACC_W'(r_ry[0]);
            tac_pkg::SRC_RX1:  v = ACC_W'(r_rx[1]);
            tac_pkg::SRC_RY1:  v = ACC_W'(r_ry[1]);
            tac_pkg::SRC_RX2:  v = ACC_W'(r_rx[2]);
            tac_pkg::SRC_RY2:  v = ACC_W'(r_ry[2]);
            tac_pkg::SRC_PX:   v = ACC_W'(r_px);
            tac_pkg::SRC_PY:   v = ACC_W'(r_py);
            tac_pkg::SRC_T0X:  v = ACC_W'(r_t0x);
            tac_pkg::SRC_T0Y:  v = ACC_W'(r_t0y);
            tac_pkg::SRC_T1X:  v = ACC_W'(r_t1x);
            tac_pkg::SRC_T1Y:  v = ACC_W'(r_t1y);
            tac_pkg::SRC_T2X:  v = ACC_W'(r_t2x);
            tac_pkg::SRC_T2Y:  v = ACC_W'(r_t2y);
            tac_pkg::SRC_VX:   v = ACC_W'(r_vx);
            tac_pkg::SRC_VY:   v = ACC_W'(r_vy);
            tac_pkg::SRC_DX12: v = r_dx12;
            tac_pkg::SRC_DY12: v = r_dy12;
            tac_pkg::SRC_C:    v = r_c;
            tac_pkg::SRC_DET:  v = r_det;
            tac_pkg::SRC_DS:   v = r_ds;
            tac_pkg::SRC_E:    v = r_e;
            tac_pkg::SRC_F:    v = r_f;
            tac_pkg::SRC_NUM:  v = r_num;
            tac_pkg::SRC_DX:   v = r_dx;
            tac_pkg::SRC_DY:   v = r_dy;
            tac_pkg::SRC_K0:   v = ACC_W'(r_coef[0]);
            tac_pkg::SRC_K1:   v = ACC_W'(r_coef[1]);
            tac_pkg::SRC_K2:   v = ACC_W'(r_coef[2]);
            tac_pkg::SRC_K3:   v = ACC_W'(r_coef[3]);
            tac_pkg::SRC_K4:   v = ACC_W'(r_coef[4]);
            tac_pkg::SRC_K5:   v = ACC_W'(r_coef[5]);
            default:           v = '0;
        endcase
        return v;
    endfunction

    // configuration targets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t0x <= 9'd25;
            r_t0y <= 8'd25;
            r_t1x <= 9'd295;
            r_t1y <= 8'd25;
            r_t2x <= 9'd295;
            r_t2y <= 8'd215;
            r_vx  <= 9'd25;
            r_vy  <= 8'd215;
        end else if (i_cfg_we) begin
            unique case (tac_pkg::t_cfg_reg'(i_cfg_index))
                tac_pkg::CFG_T0X: r_t0x <= i_cfg_data[tac_pkg::SCR_X_W-1:0];
                tac_pkg::CFG_T0Y: r_t0y <= i_cfg_data[tac_pkg::SCR_Y_W-1:0];
                tac_pkg::CFG_T1X: r_t1x <= i_cfg_data[tac_pkg::SCR_X_W-1:0];
                tac_pkg::CFG_T1Y: r_t1y <= i_cfg_data[tac_pkg::SCR_Y_W-1:0];
                tac_pkg::CFG_T2X: r_t2x <= i_cfg_data[tac_pkg::SCR_X_W-1:0];
                tac_pkg::CFG_T2Y: r_t2y <= i_cfg_data[tac_pkg::SCR_Y_W-1:0];
                tac_pkg::CFG_VX:  r_vx  <= i_cfg_data[tac_pkg::SCR_X_W-1:0];
                tac_pkg::CFG_VY:  r_vy  <= i_cfg_data[tac_pkg::SCR_Y_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_a_full = src_val(i_cmd.uop.a);
    assign w_b_full = src_val(i_cmd.uop.b);
    assign w_a      = w_a_full[A_W-1:0];
    assign w_b      = w_b_full[B_W-1:0];
    assign w_prod   = w_a * w_b;

    always_comb begin
        n_acc = (i_cmd.uop.first ? '0 : r_acc) + (i_cmd.uop.neg ? -r_prod : r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pt) begin
            r_rx[i_cmd.pt_idx] <= i_raw_x;
            r_ry[i_cmd.pt_idx] <= i_raw_y;
        end
        if (i_cmd.load_probe) begin
            r_px <= i_raw_x;
            r_py <= i_raw_y;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod[ACC_W-1:0];
        end
        if (i_cmd.acc) begin
            r_acc <= n_acc;
            if (i_cmd.uop.last) begin
                unique case (i_cmd.uop.dst)
                    tac_pkg::DST_DX12: r_dx12 <= n_acc;
                    tac_pkg::DST_DY12: r_dy12 <= n_acc;
                    tac_pkg::DST_C:    r_c    <= n_acc;
                    tac_pkg::DST_DET:  r_det  <= n_acc;
                    tac_pkg::DST_DS:   r_ds   <= n_acc;
                    tac_pkg::DST_E:    r_e    <= n_acc;
                    tac_pkg::DST_F:    r_f    <= n_acc;
                    tac_pkg::DST_NUM:  r_num  <= n_acc;
                    tac_pkg::DST_DX:   r_dx   <= n_acc;
                    tac_pkg::DST_DY:   r_dy   <= n_acc;
                    default: ;
                endcase
            end
        end
        if (i_cmd.coef_we) begin
            r_coef[i_cmd.uop.coef] <= w_quot;
        end
        if (i_cmd.load_out) begin
            for (int i = 0; i < NC; i++) begin
                r_out_coef[i] <= i_cmd.give ? r_coef[i] : '0;
            end
        end
    end

    tac_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stat.det_zero    = (r_det == '0);
    assign o_stat.verify_pass = (r_dx <= LIM) && (r_dx >= -LIM) &&
                                (r_dy <= LIM) && (r_dy >= -LIM) && (r_num <= LIM_SQ);
    assign o_stat.div_done    = w_div_done;
    assign o_coef             = r_out_coef;

endmodule

// ----- src/tac_ctrl.sv -----
// Controller: handshakes, point count and the micro-program sequencer.
module tac_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_restart,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [1:0]         o_points_taken,
    output tac_pkg::t_dp_cmd   o_cmd,
    input  tac_pkg::t_dp_stat  i_stat
);

    tac_pkg::t_state             r_state, n_state;
    logic [tac_pkg::UPC_W-1:0]   r_upc, n_upc;
    logic [1:0]                  r_count, n_count;
    tac_pkg::t_status            r_status, n_status;
    logic                        r_give, n_give;
    logic                        r_out_valid, n_out_valid;
    tac_pkg::t_status            r_out_status;
    logic [1:0]                  r_out_points;

    tac_pkg::t_uop               w_uop;
    logic                        w_accept;
    logic                        w_load;

    assign w_uop    = tac_pkg::uop_at(r_upc);
    assign w_accept = i_in_valid && (r_state == tac_pkg::ST_IDLE);
    assign w_load   = (r_state == tac_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);

    // next state
    always_comb begin
        n_state  = r_state;
        n_upc    = r_upc;
        n_count  = r_count;
        n_status = r_status;
        n_give   = r_give;
        unique case (r_state)
            tac_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_restart) begin
                        n_count  = 2'd0;
                        n_status = tac_pkg::STAT_CLEARED;
                        n_give   = 1'b0;
                        n_state  = tac_pkg::ST_DONE;
                    end else if (r_count == 2'd3) begin
                        n_count = 2'd0;
                        n_upc   = tac_pkg::PC_VERIFY;
                        n_state = tac_pkg::ST_RUN;
                    end else begin
                        n_count = r_count + 2'd1;
                        if (r_count == 2'd2) begin
                            n_upc   = tac_pkg::PC_SOLVE;
                            n_state = tac_pkg::ST_RUN;
                        end else begin
                            n_status = tac_pkg::STAT_STORED;
                            n_give   = 1'b0;
                            n_state  = tac_pkg::ST_DONE;
                        end
                    end
                end
            end
            tac_pkg::ST_RUN: begin
                unique case (w_uop.kind)
                    tac_pkg::UOP_MAC: n_state = tac_pkg::ST_ACC;
                    tac_pkg::UOP_DIV: n_state = tac_pkg::ST_DIV;
                    tac_pkg::UOP_CHKDET: begin
                        if (i_stat.det_zero) begin
                            n_count  = 2'd0;
                            n_status = tac_pkg::STAT_DEGENERATE;
                            n_give   = 1'b0;
                            n_state  = tac_pkg::ST_DONE;
                        end else begin
                            n_upc = r_upc + 1'b1;
                        end
                    end
                    tac_pkg::UOP_ENDSOLVE: begin
                        n_status = tac_pkg::STAT_STORED;
                        n_give   = 1'b0;
                        n_state  = tac_pkg::ST_DONE;
                    end
                    tac_pkg::UOP_ENDVERIFY: begin
                        n_status = i_stat.verify_pass ? tac_pkg::STAT_VERIFIED
                                                      : tac_pkg::STAT_FAILED;
                        n_give   = i_stat.verify_pass;
                        n_state  = tac_pkg::ST_DONE;
                    end
                    default: n_state = tac_pkg::ST_DONE;
                endcase
            end
            tac_pkg::ST_ACC: begin
                n_upc   = r_upc + 1'b1;
                n_state = tac_pkg::ST_RUN;
            end
            tac_pkg::ST_DIV: begin
                if (i_stat.div_done) begin
                    n_upc   = r_upc + 1'b1;
                    n_state = tac_pkg::ST_RUN;
                end
            end
            tac_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = tac_pkg::ST_IDLE;
                end
            end
            default: n_state = tac_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.uop        = w_uop;
        o_cmd.store_pt   = w_accept && !i_restart && (r_count != 2'd3);
        o_cmd.pt_idx     = r_count;
        o_cmd.load_probe = w_accept && !i_restart && (r_count == 2'd3);
        o_cmd.mul        = (r_state == tac_pkg::ST_RUN) && (w_uop.kind == tac_pkg::UOP_MAC);
        o_cmd.acc        = (r_state == tac_pkg::ST_ACC);
        o_cmd.div_start  = (r_state == tac_pkg::ST_RUN) && (w_uop.kind == tac_pkg::UOP_DIV);
        o_cmd.coef_we    = (r_state == tac_pkg::ST_DIV) && i_stat.div_done;
        o_cmd.load_out   = w_load;
        o_cmd.give       = r_give;
        n_out_valid      = w_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tac_pkg::ST_IDLE;
            r_upc       <= '0;
            r_count     <= 2'd0;
            r_status    <= tac_pkg::STAT_STORED;
            r_give      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_upc       <= n_upc;
            r_count     <= n_count;
            r_status    <= n_status;
            r_give      <= n_give;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_points <= r_count;
        end
    end

    assign o_in_stall     = (r_state != tac_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_points_taken = r_out_points;

    a_stored_has_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == tac_pkg::STAT_STORED)) |-> (r_out_points != 2'd0))
        else $error("stored item reports no points");

    a_other_clears_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != tac_pkg::STAT_STORED)) |-> (r_out_points == 2'd0))
        else $error("non-store item keeps points");

    a_div_state_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tac_pkg::ST_DIV) |-> (w_uop.kind == tac_pkg::UOP_DIV))
        else $error("divide wait on a non-divide op");

    a_acc_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tac_pkg::ST_ACC) |-> ($past(r_state) == tac_pkg::ST_RUN))
        else $error("accumulate without multiply");

endmodule
